/* rtl/rpps_pkg.sv */
// ----------------------------------------------------------------------------
// rpps_pkg
// types and constants for the reach / push phase sequencer
// ----------------------------------------------------------------------------
package rpps_pkg;

    localparam int CMD_W      = 3;
    localparam int MASK_W     = 12;
    localparam int REPLY_W    = 2;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ARM_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FING_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_TIMEOUT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] ARM_TIMEOUT_RST  = 16'd500;
    localparam logic [CFG_DATA_W-1:0] FING_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] PUSH_TIMEOUT_RST = 16'd400;

    localparam logic [MASK_W-1:0] A_VISUAL    = 12'h001;
    localparam logic [MASK_W-1:0] A_TACTILE   = 12'h002;
    localparam logic [MASK_W-1:0] A_FILT_OFF  = 12'h004;
    localparam logic [MASK_W-1:0] A_ARM_APP   = 12'h008;
    localparam logic [MASK_W-1:0] A_FING_APP  = 12'h010;
    localparam logic [MASK_W-1:0] A_FOLLOW    = 12'h020;
    localparam logic [MASK_W-1:0] A_PUSH      = 12'h040;
    localparam logic [MASK_W-1:0] A_HOME      = 12'h080;
    localparam logic [MASK_W-1:0] A_FING_REST = 12'h100;
    localparam logic [MASK_W-1:0] A_ARM_STOP  = 12'h200;
    localparam logic [MASK_W-1:0] A_FING_STOP = 12'h400;
    localparam logic [MASK_W-1:0] A_CTX_REST  = 12'h800;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_HOME_R = 3'd1,
        CMD_HOME_L = 3'd2,
        CMD_LOCAL  = 3'd3,
        CMD_APP_R  = 3'd4,
        CMD_PUSH_R = 3'd5,
        CMD_STOP   = 3'd6
    } cmd_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE           = 4'd0,
        PH_LOCALIZE       = 4'd1,
        PH_ARM_APP        = 4'd2,
        PH_WAIT_ARM_APP   = 4'd3,
        PH_FING_APP       = 4'd4,
        PH_WAIT_FING_APP  = 4'd5,
        PH_PUSH           = 4'd6,
        PH_WAIT_PUSH      = 4'd7,
        PH_ARM_HOME       = 4'd8,
        PH_WAIT_ARM_HOME  = 4'd9,
        PH_FING_REST      = 4'd10,
        PH_WAIT_FING_REST = 4'd11,
        PH_STOP           = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_RIGHT = 2'd1,
        SIDE_LEFT  = 2'd2
    } side_t;

    typedef enum logic [REPLY_W-1:0] {
        REPLY_TICK   = 2'd0,
        REPLY_ACCEPT = 2'd1,
        REPLY_BUSY   = 2'd2
    } reply_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             query_ok;
        logic             motion_done;
        logic             estimate_available;
    } in_item_t;

    typedef struct packed {
        phase_t phase;
        side_t  side;
        logic   approach_done;
        logic   stopped_push;
    } seq_state_t;

    typedef struct packed {
        logic [MASK_W-1:0] action_mask;
        logic              action_hand;
        reply_t            reply;
        phase_t            phase_now;
        logic              approach_ready;
    } out_item_t;

endpackage

/* rtl/rpps_if.sv */
// ----------------------------------------------------------------------------
// rpps_if
// valid / ready channels for the sequencer input items and results
// ----------------------------------------------------------------------------
interface rpps_in_if;
    logic                       valid;
    logic                       ready;
    logic [rpps_pkg::CMD_W-1:0] cmd;
    logic                       query_ok;
    logic                       motion_done;
    logic                       estimate_available;

    modport source (
        output valid,
        output cmd,
        output query_ok,
        output motion_done,
        output estimate_available,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  query_ok,
        input  motion_done,
        input  estimate_available,
        output ready
    );
endinterface

interface rpps_out_if;
    logic                         valid;
    logic                         ready;
    logic [rpps_pkg::MASK_W-1:0]  action_mask;
    logic                         action_hand;
    logic [rpps_pkg::REPLY_W-1:0] reply;
    logic [rpps_pkg::PHASE_W-1:0] phase_now;
    logic                         approach_ready;

    modport source (
        output valid,
        output action_mask,
        output action_hand,
        output reply,
        output phase_now,
        output approach_ready,
        input  ready
    );

    modport sink (
        input  valid,
        input  action_mask,
        input  action_hand,
        input  reply,
        input  phase_now,
        input  approach_ready,
        output ready
    );
endinterface

/* rtl/rpps_step.sv */
// ----------------------------------------------------------------------------
// rpps_step
// phase transition, action strobes and timeout check for one item
// ----------------------------------------------------------------------------
module rpps_step #(
    parameter int TIMER_BITS = 16
) (
    input  rpps_pkg::in_item_t                item,
    input  rpps_pkg::seq_state_t              state,
    input  logic [TIMER_BITS-1:0]             elapsed,
    input  logic [rpps_pkg::CFG_DATA_W-1:0]   arm_timeout,
    input  logic [rpps_pkg::CFG_DATA_W-1:0]   fing_timeout,
    input  logic [rpps_pkg::CFG_DATA_W-1:0]   push_timeout,
    output rpps_pkg::seq_state_t              state_next,
    output logic [TIMER_BITS-1:0]             elapsed_next,
    output rpps_pkg::out_item_t               result
);

    localparam int CMP_W = (TIMER_BITS > rpps_pkg::CFG_DATA_W) ?
                           TIMER_BITS : rpps_pkg::CFG_DATA_W;

    logic                            has_hand;
    logic                            ok;
    logic                            done;
    logic                            timed_out;
    logic [TIMER_BITS-1:0]           elapsed_inc;
    logic [rpps_pkg::CFG_DATA_W-1:0] limit;
    logic [rpps_pkg::MASK_W-1:0]     mask;
    rpps_pkg::reply_t                reply;
    rpps_pkg::cmd_t                  cmd;

    assign cmd      = rpps_pkg::cmd_t'(item.cmd);
    assign has_hand = (state.side == rpps_pkg::SIDE_RIGHT) ||
                      (state.side == rpps_pkg::SIDE_LEFT);
    assign ok       = has_hand && item.query_ok;
    assign done     = ok && item.motion_done;

    // saturating wait counter
    assign elapsed_inc = (elapsed == {TIMER_BITS{1'b1}}) ? elapsed
                                                          : elapsed + TIMER_BITS'(1);

    always_comb
    begin
        case (state.phase)
            rpps_pkg::PH_WAIT_ARM_APP,
            rpps_pkg::PH_WAIT_ARM_HOME:  limit = arm_timeout;
            rpps_pkg::PH_WAIT_FING_APP,
            rpps_pkg::PH_WAIT_FING_REST: limit = fing_timeout;
            default:                     limit = push_timeout;
        endcase
    end

    assign timed_out = CMP_W'(elapsed_inc) > CMP_W'(limit);

    always_comb
    begin
        state_next   = state;
        elapsed_next = elapsed;
        mask         = '0;
        reply        = rpps_pkg::REPLY_TICK;

        case (cmd)
            rpps_pkg::CMD_HOME_R,
            rpps_pkg::CMD_HOME_L,
            rpps_pkg::CMD_LOCAL,
            rpps_pkg::CMD_APP_R,
            rpps_pkg::CMD_PUSH_R:
            begin
                if (state.phase != rpps_pkg::PH_IDLE)
                begin
                    reply = rpps_pkg::REPLY_BUSY;
                end
                else
                begin
                    reply                   = rpps_pkg::REPLY_ACCEPT;
                    state_next.stopped_push = 1'b0;
                    case (cmd)
                        rpps_pkg::CMD_HOME_R:
                        begin
                            state_next.phase = rpps_pkg::PH_FING_REST;
                            state_next.side  = rpps_pkg::SIDE_RIGHT;
                        end
                        rpps_pkg::CMD_HOME_L:
                        begin
                            state_next.phase = rpps_pkg::PH_FING_REST;
                            state_next.side  = rpps_pkg::SIDE_LEFT;
                        end
                        rpps_pkg::CMD_LOCAL:
                        begin
                            state_next.phase = rpps_pkg::PH_LOCALIZE;
                        end
                        rpps_pkg::CMD_APP_R:
                        begin
                            state_next.phase = rpps_pkg::PH_ARM_APP;
                            state_next.side  = rpps_pkg::SIDE_RIGHT;
                        end
                        default:
                        begin
                            state_next.phase = rpps_pkg::PH_PUSH;
                            state_next.side  = rpps_pkg::SIDE_RIGHT;
                        end
                    endcase
                end
            end

            rpps_pkg::CMD_STOP:
            begin
                reply                   = rpps_pkg::REPLY_ACCEPT;
                state_next.stopped_push = (state.phase == rpps_pkg::PH_PUSH) ||
                                          (state.phase == rpps_pkg::PH_WAIT_PUSH);
                state_next.phase        = rpps_pkg::PH_STOP;
            end

            rpps_pkg::CMD_TICK:
            begin
                case (state.phase)
                    rpps_pkg::PH_IDLE:
                    begin
                        state_next.phase = rpps_pkg::PH_IDLE;
                    end

                    rpps_pkg::PH_LOCALIZE:
                    begin
                        mask             = rpps_pkg::A_VISUAL;
                        state_next.phase = rpps_pkg::PH_IDLE;
                    end

                    rpps_pkg::PH_ARM_APP:
                    begin
                        state_next.approach_done = 1'b0;
                        if (!has_hand)
                        begin
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        else
                        begin
                            if (item.estimate_available)
                                mask = rpps_pkg::A_ARM_APP;
                            state_next.phase = rpps_pkg::PH_WAIT_ARM_APP;
                            elapsed_next     = '0;
                        end
                    end

                    rpps_pkg::PH_WAIT_ARM_APP:
                    begin
                        elapsed_next = elapsed_inc;
                        if (!ok || timed_out)
                        begin
                            mask             = rpps_pkg::A_ARM_STOP;
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        if (done)
                            state_next.phase = rpps_pkg::PH_FING_APP;
                    end

                    rpps_pkg::PH_FING_APP:
                    begin
                        if (!has_hand)
                        begin
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        else
                        begin
                            mask             = rpps_pkg::A_FING_APP;
                            state_next.phase = rpps_pkg::PH_WAIT_FING_APP;
                            elapsed_next     = '0;
                        end
                    end

                    rpps_pkg::PH_WAIT_FING_APP:
                    begin
                        elapsed_next = elapsed_inc;
                        if (!ok || timed_out)
                        begin
                            mask             = rpps_pkg::A_FING_STOP;
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        if (done)
                        begin
                            state_next.phase         = rpps_pkg::PH_IDLE;
                            state_next.approach_done = 1'b1;
                        end
                    end

                    rpps_pkg::PH_PUSH:
                    begin
                        if (!state.approach_done)
                        begin
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        else
                        begin
                            mask = rpps_pkg::A_PUSH | rpps_pkg::A_TACTILE |
                                   rpps_pkg::A_FOLLOW;
                            state_next.phase = rpps_pkg::PH_WAIT_PUSH;
                            elapsed_next     = '0;
                        end
                    end

                    rpps_pkg::PH_WAIT_PUSH:
                    begin
                        elapsed_next = elapsed_inc;
                        if (!ok || timed_out || done)
                        begin
                            mask = rpps_pkg::A_ARM_STOP | rpps_pkg::A_FING_STOP |
                                   rpps_pkg::A_FILT_OFF | rpps_pkg::A_CTX_REST;
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                    end

                    rpps_pkg::PH_FING_REST:
                    begin
                        if (!has_hand)
                        begin
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        else
                        begin
                            mask             = rpps_pkg::A_FING_REST;
                            state_next.phase = rpps_pkg::PH_WAIT_FING_REST;
                            elapsed_next     = '0;
                        end
                    end

                    rpps_pkg::PH_WAIT_FING_REST:
                    begin
                        elapsed_next = elapsed_inc;
                        if (!ok || timed_out)
                        begin
                            mask             = rpps_pkg::A_FING_STOP;
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        if (done)
                            state_next.phase = rpps_pkg::PH_ARM_HOME;
                    end

                    rpps_pkg::PH_ARM_HOME:
                    begin
                        if (!has_hand)
                        begin
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        else
                        begin
                            mask             = rpps_pkg::A_HOME;
                            state_next.phase = rpps_pkg::PH_WAIT_ARM_HOME;
                            elapsed_next     = '0;
                        end
                    end

                    rpps_pkg::PH_WAIT_ARM_HOME:
                    begin
                        elapsed_next = elapsed_inc;
                        if (!ok || timed_out)
                        begin
                            mask             = rpps_pkg::A_ARM_STOP;
                            state_next.phase = rpps_pkg::PH_IDLE;
                        end
                        if (done)
                            state_next.phase = rpps_pkg::PH_IDLE;
                    end

                    rpps_pkg::PH_STOP:
                    begin
                        mask = rpps_pkg::A_ARM_STOP | rpps_pkg::A_FING_STOP |
                               rpps_pkg::A_FILT_OFF;
                        if (state.stopped_push)
                            mask = mask | rpps_pkg::A_CTX_REST;
                        state_next.approach_done = 1'b0;
                        state_next.phase         = rpps_pkg::PH_IDLE;
                    end

                    default:
                    begin
                        state_next.phase = rpps_pkg::PH_IDLE;
                    end
                endcase
            end

            default:
            begin
                // unused command code: no effect
                reply = rpps_pkg::REPLY_TICK;
            end
        endcase
    end

    assign result.action_mask    = mask;
    assign result.action_hand    = (state_next.side == rpps_pkg::SIDE_RIGHT) ? 1'b0 : 1'b1;
    assign result.reply          = reply;
    assign result.phase_now      = state_next.phase;
    assign result.approach_ready = state_next.approach_done;

endmodule

/* rtl/reach_push_phase_sequencer_top.sv */
// ----------------------------------------------------------------------------
// reach_push_phase_sequencer_top
// reach / push / home / localize phase sequencer with tick-counted timeouts
// ----------------------------------------------------------------------------
// path: each item is held in the input register, then its result in the result register,
// which keeps its value while the output channel stalls
// throughput: one item per cycle while the output is not stalled; state updates once per item
// reset: phase idle, no hand chosen, flags and wait counter cleared,
// timeout registers at 500 / 1000 / 400 ticks
module reach_push_phase_sequencer_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rpps_in_if.sink                         in_ch,
    rpps_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [rpps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpps_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                            in_vld_reg;
    logic                            in_vld_next;
    rpps_pkg::in_item_t              in_item_reg;
    rpps_pkg::in_item_t              in_item_next;
    rpps_pkg::seq_state_t            state_reg;
    rpps_pkg::seq_state_t            state_next;
    logic [TIMER_BITS-1:0]           elapsed_reg;
    logic [TIMER_BITS-1:0]           elapsed_next;
    logic [rpps_pkg::CFG_DATA_W-1:0] arm_timeout_reg;
    logic [rpps_pkg::CFG_DATA_W-1:0] fing_timeout_reg;
    logic [rpps_pkg::CFG_DATA_W-1:0] push_timeout_reg;
    logic                            out_vld_reg;
    logic                            out_vld_next;
    rpps_pkg::out_item_t             out_item_reg;
    rpps_pkg::out_item_t             out_item_next;
    rpps_pkg::seq_state_t            step_state;
    logic [TIMER_BITS-1:0]           step_elapsed;
    rpps_pkg::out_item_t             step_result;
    logic                            advance;
    logic                            fire;
    logic                            in_xfer;

    assign advance   = !out_vld_reg || out_ch.ready;
    assign fire      = in_vld_reg && advance;
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_xfer   = in_ch.valid && in_ch.ready;

    rpps_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item         (in_item_reg),
        .state        (state_reg),
        .elapsed      (elapsed_reg),
        .arm_timeout  (arm_timeout_reg),
        .fing_timeout (fing_timeout_reg),
        .push_timeout (push_timeout_reg),
        .state_next   (step_state),
        .elapsed_next (step_elapsed),
        .result       (step_result)
    );

    always_comb
    begin
        in_vld_next  = in_ch.ready ? in_ch.valid : in_vld_reg;
        in_item_next = in_item_reg;
        if (in_xfer)
        begin
            in_item_next.cmd                = in_ch.cmd;
            in_item_next.query_ok           = in_ch.query_ok;
            in_item_next.motion_done        = in_ch.motion_done;
            in_item_next.estimate_available = in_ch.estimate_available;
        end
        state_next    = fire ? step_state : state_reg;
        elapsed_next  = fire ? step_elapsed : elapsed_reg;
        out_vld_next  = advance ? in_vld_reg : out_vld_reg;
        out_item_next = fire ? step_result : out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg               <= 1'b0;
            out_vld_reg              <= 1'b0;
            state_reg.phase          <= rpps_pkg::PH_IDLE;
            state_reg.side           <= rpps_pkg::SIDE_NONE;
            state_reg.approach_done  <= 1'b0;
            state_reg.stopped_push   <= 1'b0;
            elapsed_reg              <= '0;
            arm_timeout_reg          <= rpps_pkg::ARM_TIMEOUT_RST;
            fing_timeout_reg         <= rpps_pkg::FING_TIMEOUT_RST;
            push_timeout_reg         <= rpps_pkg::PUSH_TIMEOUT_RST;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rpps_pkg::CFG_ARM_TIMEOUT:  arm_timeout_reg  <= cfg_data;
                    rpps_pkg::CFG_FING_TIMEOUT: fing_timeout_reg <= cfg_data;
                    rpps_pkg::CFG_PUSH_TIMEOUT: push_timeout_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.action_mask    = out_item_reg.action_mask;
    assign out_ch.action_hand    = out_item_reg.action_hand;
    assign out_ch.reply          = out_item_reg.reply;
    assign out_ch.phase_now      = out_item_reg.phase_now;
    assign out_ch.approach_ready = out_item_reg.approach_ready;

    a_state_only_on_fire: assert property (
        @(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(state_reg) && $stable(elapsed_reg))
    ) else $error("sequencer state changed without an item");

    a_cmd_no_strobes: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_item_reg.reply != rpps_pkg::REPLY_TICK))
            |-> (out_item_reg.action_mask == '0)
    ) else $error("command item issued action strobes");

    a_busy_not_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && (step_result.reply == rpps_pkg::REPLY_BUSY))
            |=> (state_reg.phase != rpps_pkg::PH_IDLE)
    ) else $error("busy reply while sequencer idle");

    a_result_tracks_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire |=> (out_item_reg.phase_now == state_reg.phase)
    ) else $error("reported phase differs from stored phase");

endmodule
